>>> hdl/imu_bias_calibrate_and_scale_macros.svh
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - assertion macros
// Clocked property shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_AND_SCALE_MACROS_SVH
`define IMU_BIAS_CALIBRATE_AND_SCALE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IBCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibcs: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define IBCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibcs: next-cycle check failed");

`endif

>>> hdl/ibcs_pkg.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - package
// Widths, codes, range tables and divider constants.
// ----------------------------------------------------------------------------
package ibcs_pkg;

    // calibration window length
    localparam int SAMPLES = 1000;

    localparam int RAW_W = 16;
    localparam int OFF_W = 18;
    localparam int SUM_W = 28;
    localparam int CNT_W = 10;
    localparam int OUT_W = 32;
    localparam int RNG_W = 11;
    localparam int AXES  = 3;

    // raw + offset
    localparam int VAL_W = OFF_W + 1;

    // offset numerators: -sum, or full-scale bias minus twice the sum
    localparam int NUM_W = SUM_W + 2;
    localparam int FULL_SCALE = 32767;
    localparam int ACCEL_Z_NUM = FULL_SCALE * SAMPLES;

    // reciprocal for floor(n / SAMPLES), n below 2**DIV_N
    localparam int DIV_N   = SUM_W;
    localparam int DIV_L   = $clog2(SAMPLES);
    localparam int DIV_K   = DIV_N + DIV_L;
    localparam int DIV_M_W = DIV_N + 2;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_K) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

    typedef enum logic {
        OP_CALIB   = 1'b0,
        OP_CONVERT = 1'b1
    } t_opcode;

    typedef enum logic {
        SENS_GYRO  = 1'b0,
        SENS_ACCEL = 1'b1
    } t_sensor;

    typedef enum logic {
        REG_GYRO_RANGE  = 1'b0,
        REG_ACCEL_RANGE = 1'b1
    } t_reg_idx;

    // full scale in dps and g
    localparam logic [RNG_W-1:0] GYRO_RANGE [4] = '{
        11'd250, 11'd500, 11'd1000, 11'd2000
    };
    localparam logic [RNG_W-1:0] ACCEL_RANGE [4] = '{
        11'd2, 11'd4, 11'd8, 11'd16
    };

endpackage

>>> hdl/imu_bias_calibrate_and_scale.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - top level
// Averages calibration samples into per-sensor offsets and scales every
// three-axis sample to signed Q.16 dps or g.
//
//   channel   dir  data                                   user
//   s (in)    in   raw_x[15:0] raw_y[31:16] raw_z[47:32]   opcode[0] sensor_sel[1]
//   m (out)   out  true_x[31:0] true_y[63:32] true_z[95:64] sensor_echo[0] calib_done[1]
//   cfg       in   wr_en, idx (0 gyro range, 1 accel range), wdata[1:0]
//
// One request per cycle while o_s_tready is high, via input and result registers.
// The request that closes a calibration window drops o_s_tready for one
// cycle while the reciprocal multipliers load the new offsets.
// A stalled result holds in the output register; one more request is taken
// into the input register behind it. Synchronous reset clears all sums,
// counts, offsets and ranges.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_scale
    import ibcs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [3*RAW_W-1:0]       i_s_tdata,   // raw_x, raw_y, raw_z
    input  logic [1:0]               i_s_tuser,   // opcode, sensor_sel
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [3*OUT_W-1:0]       o_m_tdata,   // true_x, true_y, true_z
    output logic [1:0]               o_m_tuser,   // sensor_echo, calib_done
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_idx,
    input  logic [1:0]               i_cfg_wdata
);

    logic [1:0] r_gyro_rng;
    logic [1:0] r_accel_rng;

    logic signed [OFF_W-1:0] r_gyro_off  [AXES];
    logic signed [OFF_W-1:0] r_accel_off [AXES];
    logic signed [SUM_W-1:0] r_gyro_sum  [AXES];
    logic signed [SUM_W-1:0] r_accel_sum [AXES];
    logic        [CNT_W-1:0] r_gyro_cnt;
    logic        [CNT_W-1:0] r_accel_cnt;
    logic                    r_pend;
    logic                    r_pend_sens;

    logic signed [OFF_W-1:0] n_gyro_off  [AXES];
    logic signed [OFF_W-1:0] n_accel_off [AXES];
    logic signed [SUM_W-1:0] n_gyro_sum  [AXES];
    logic signed [SUM_W-1:0] n_accel_sum [AXES];
    logic        [CNT_W-1:0] n_gyro_cnt;
    logic        [CNT_W-1:0] n_accel_cnt;
    logic                    n_pend;
    logic                    n_pend_sens;

    logic                    r_s1_vld;
    logic signed [VAL_W-1:0] r_s1_val [AXES];
    logic        [RNG_W-1:0] r_s1_rng;
    logic                    r_s1_sens;
    logic                    r_s1_done;

    logic                    r_out_vld;
    logic signed [OUT_W-1:0] r_out_true [AXES];
    logic                    r_out_sens;
    logic                    r_out_done;

    logic                    w_in_acc;
    logic                    w_s1_mv;
    logic                    w_op;
    logic                    w_sens;
    logic signed [RAW_W-1:0] w_raw     [AXES];
    logic signed [VAL_W-1:0] w_val     [AXES];
    logic signed [SUM_W-1:0] w_new_sum [AXES];
    logic        [CNT_W-1:0] w_cnt_inc;
    logic                    w_cmp;
    logic        [RNG_W-1:0] w_rng;
    logic signed [SUM_W-1:0] w_pend_sum [AXES];
    logic signed [NUM_W-1:0] w_num      [AXES];
    logic                    w_half     [AXES];
    logic signed [OFF_W-1:0] w_div_off  [AXES];
    logic signed [OUT_W-1:0] w_true     [AXES];

    assign w_op     = i_s_tuser[0];
    assign w_sens   = i_s_tuser[1];
    assign w_s1_mv  = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_pend && (!r_s1_vld || w_s1_mv);
    assign w_in_acc = i_s_tvalid && o_s_tready;

    assign w_cnt_inc = ((w_sens == SENS_ACCEL) ? r_accel_cnt : r_gyro_cnt) + CNT_W'(1);
    assign w_cmp     = (w_cnt_inc >= CNT_W'(SAMPLES));
    assign w_rng     = (w_sens == SENS_ACCEL) ? ACCEL_RANGE[r_accel_rng]
                                              : GYRO_RANGE[r_gyro_rng];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_raw[i] = $signed(i_s_tdata[i*RAW_W +: RAW_W]);
            w_val[i] = VAL_W'(w_raw[i]) + ((w_sens == SENS_ACCEL)
                       ? VAL_W'(r_accel_off[i]) : VAL_W'(r_gyro_off[i]));
            w_new_sum[i] = ((w_sens == SENS_ACCEL) ? r_accel_sum[i] : r_gyro_sum[i])
                           + SUM_W'(w_raw[i]);
            w_pend_sum[i] = (r_pend_sens == SENS_ACCEL) ? r_accel_sum[i] : r_gyro_sum[i];
            w_half[i] = (i == AXES - 1) && (r_pend_sens == SENS_ACCEL);
            // accel Z keeps one g: (32767 * S - 2 * sum) / 2S
            if (w_half[i]) begin
                w_num[i] = NUM_W'(ACCEL_Z_NUM) - (NUM_W'(w_pend_sum[i]) <<< 1);
            end else begin
                w_num[i] = -NUM_W'(w_pend_sum[i]);
            end
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        ibcs_offset_div u_div (
            .i_num  (w_num[g]),
            .i_half (w_half[g]),
            .o_off  (w_div_off[g])
        );

        ibcs_axis_scale u_scale (
            .i_val    (r_s1_val[g]),
            .i_range  (r_s1_rng),
            .o_result (w_true[g])
        );
    end

    // calibration state next values
    always_comb begin
        n_gyro_off  = r_gyro_off;
        n_accel_off = r_accel_off;
        n_gyro_sum  = r_gyro_sum;
        n_accel_sum = r_accel_sum;
        n_gyro_cnt  = r_gyro_cnt;
        n_accel_cnt = r_accel_cnt;
        n_pend      = 1'b0;
        n_pend_sens = r_pend_sens;
        if (r_pend) begin
            // load offsets from the closed window, restart its sums
            for (int i = 0; i < AXES; i++) begin
                if (r_pend_sens == SENS_ACCEL) begin
                    n_accel_off[i] = w_div_off[i];
                    n_accel_sum[i] = '0;
                end else begin
                    n_gyro_off[i] = w_div_off[i];
                    n_gyro_sum[i] = '0;
                end
            end
        end else if (w_in_acc && (w_op == OP_CALIB)) begin
            if (w_sens == SENS_ACCEL) begin
                n_accel_sum = w_new_sum;
                n_accel_cnt = w_cmp ? '0 : w_cnt_inc;
            end else begin
                n_gyro_sum = w_new_sum;
                n_gyro_cnt = w_cmp ? '0 : w_cnt_inc;
            end
            if (w_cmp) begin
                n_pend      = 1'b1;
                n_pend_sens = w_sens;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_rng  <= '0;
            r_accel_rng <= '0;
            r_gyro_cnt  <= '0;
            r_accel_cnt <= '0;
            r_pend      <= 1'b0;
            r_pend_sens <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_gyro_off[i]  <= '0;
                r_accel_off[i] <= '0;
                r_gyro_sum[i]  <= '0;
                r_accel_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_GYRO_RANGE:  r_gyro_rng  <= i_cfg_wdata;
                    REG_ACCEL_RANGE: r_accel_rng <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_gyro_off  <= n_gyro_off;
            r_accel_off <= n_accel_off;
            r_gyro_sum  <= n_gyro_sum;
            r_accel_sum <= n_accel_sum;
            r_gyro_cnt  <= n_gyro_cnt;
            r_accel_cnt <= n_accel_cnt;
            r_pend      <= n_pend;
            r_pend_sens <= n_pend_sens;
        end
    end

    // input register: offset already applied, range looked up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_mv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_val  <= w_val;
            r_s1_rng  <= w_rng;
            r_s1_sens <= w_sens;
            r_s1_done <= (w_op == OP_CALIB) && w_cmp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_mv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_mv) begin
            r_out_true <= w_true;
            r_out_sens <= r_s1_sens;
            r_out_done <= r_s1_done;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_true[2], r_out_true[1], r_out_true[0]};
    assign o_m_tuser  = {r_out_done, r_out_sens};

endmodule

>>> hdl/ibcs_axis_scale.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - axis scaler
// (raw + offset) * range * 65536 / 32767, truncated toward zero, Q.16.
// ----------------------------------------------------------------------------
module ibcs_axis_scale
    import ibcs_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_val,
    input  logic        [RNG_W-1:0] i_range,
    output logic signed [OUT_W-1:0] o_result
);

    localparam int PROD_W = VAL_W + RNG_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int N2_W   = PROD_W;
    localparam int HI_W   = N2_W - 15;

    logic signed [PROD_W-1:0] w_prod;
    logic                     w_neg;
    logic        [MAG_W-1:0]  w_mag;
    logic        [N2_W-1:0]   w_n2;
    logic        [HI_W-1:0]   w_hi;
    logic        [HI_W:0]     w_s;
    logic        [1:0]        w_s_hi;
    logic        [15:0]       w_t;
    logic                     w_corr;
    logic        [HI_W:0]     w_quot;
    logic        [OUT_W-1:0]  w_total;

    assign w_prod = i_val * $signed({1'b0, i_range});
    assign w_neg  = w_prod[PROD_W-1];
    assign w_mag  = w_neg ? MAG_W'(-w_prod) : MAG_W'(w_prod);

    // m * 65536 / 32767 = 2m + 2m / 32767; split 2m on 2**15 = 32767 + 1
    assign w_n2   = {w_mag, 1'b0};
    assign w_hi   = w_n2[N2_W-1:15];
    assign w_s    = {1'b0, w_hi} + (HI_W + 1)'(w_n2[14:0]);
    assign w_s_hi = 2'(w_s[HI_W:15]);
    assign w_t    = 16'(w_s_hi) + 16'(w_s[14:0]);
    assign w_corr = (w_t >= 16'(FULL_SCALE));
    assign w_quot = {1'b0, w_hi} + (HI_W + 1)'(w_s_hi) + (HI_W + 1)'(w_corr);

    assign w_total  = OUT_W'(w_n2) + OUT_W'(w_quot);
    assign o_result = w_neg ? $signed(-w_total) : $signed(w_total);

endmodule

>>> hdl/ibcs_offset_div.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - offset divider
// Truncating divide of a signed numerator by SAMPLES or twice SAMPLES.
// ----------------------------------------------------------------------------
module ibcs_offset_div
    import ibcs_pkg::*;
(
    input  logic signed [NUM_W-1:0] i_num,
    input  logic                    i_half,
    output logic signed [OFF_W-1:0] o_off
);

    localparam int PROD_W = DIV_N + DIV_M_W;

    logic                w_neg;
    logic [DIV_N-1:0]    w_mag;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_q;
    logic [PROD_W-1:0]   w_qh;
    logic [OFF_W-1:0]    w_qt;

    assign w_neg  = i_num[NUM_W-1];
    assign w_mag  = w_neg ? DIV_N'(-i_num) : DIV_N'(i_num);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(DIV_M_W'(DIV_M));
    assign w_q    = w_prod >> DIV_K;
    // floor(n / 2S) = floor(floor(n / S) / 2)
    assign w_qh   = i_half ? (w_q >> 1) : w_q;
    assign w_qt   = w_qh[OFF_W-1:0];
    assign o_off  = w_neg ? $signed(-w_qt) : $signed(w_qt);

endmodule

>>> hdl/ibcs_checker.sv
// ----------------------------------------------------------------------------
// IMU bias calibrate and scale - port checker
// Watches the top-level ports for stall and ready behavior.
// ----------------------------------------------------------------------------
`include "imu_bias_calibrate_and_scale_macros.svh"

module ibcs_checker
    import ibcs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [3*OUT_W-1:0]   o_m_tdata,
    input logic [1:0]           o_m_tuser
);

    logic w_in_acc;

    assign w_in_acc = i_s_tvalid && o_s_tready;

    // a stalled result holds
    `IBCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready), (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))

    // with the output empty, ready drops for one cycle at most (offset load)
    `IBCS_ASSERT_NEXT(a_ready_gap, i_clk, i_rst_n, (!o_m_tvalid && !o_s_tready), (o_s_tready))

    // no recent request and an empty output leave the block ready
    `IBCS_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, (!$past(w_in_acc) && !$past(w_in_acc, 2) && !$past(o_m_tvalid)), (o_s_tready))

endmodule

bind imu_bias_calibrate_and_scale ibcs_checker u_ibcs_checker (.*);
